[hdl/bli_pkg.sv]
package bli_pkg;

    // Fixed field widths
    localparam int INTENSITY_BITS = 16;
    localparam int CHANNEL_BITS   = 3;
    localparam int INDEX_BITS     = 2;

    // Cosine quarter-wave table
    localparam int COS_DEPTH = 256;
    localparam int COS_IDX_W = $clog2(COS_DEPTH);
    localparam int COS_SEL_W = COS_IDX_W + 1;
    localparam int COS_W     = 15;
    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

    // Phase divider: one quotient bit per step over the full dividend
    localparam int DIV_STEPS  = 2 * INTENSITY_BITS;
    localparam int LOOP_W     = $clog2(DIV_STEPS);

    // Microcode store
    localparam int UCODE_DEPTH = 8;
    localparam int STEP_W      = $clog2(UCODE_DEPTH);

    // Configuration register indexes
    localparam logic [1:0] CFG_MAX_INTENSITY  = 2'd0;
    localparam logic [1:0] CFG_START_PHASE    = 2'd1;
    localparam logic [1:0] CFG_TARGET_CHANNEL = 2'd2;

    // Program step addresses
    localparam logic [STEP_W-1:0] STEP_ACCEPT = 3'd0;
    localparam logic [STEP_W-1:0] STEP_DIV    = 3'd2;
    localparam logic [STEP_W-1:0] STEP_EMIT   = 3'd6;

    typedef enum logic [2:0] {
        UOP_NOP,
        UOP_ACCEPT,
        UOP_DIV_INIT,
        UOP_DIV_ITER,
        UOP_LOOKUP,
        UOP_SQUARE,
        UOP_SCALE,
        UOP_EMIT
    } t_uop;

    typedef enum logic [2:0] {
        COND_NEVER,
        COND_ALWAYS,
        COND_NO_INPUT,
        COND_LOOP_MORE,
        COND_OUT_BUSY
    } t_cond;

    typedef struct packed {
        t_uop                uop;
        t_cond               cond;
        logic [STEP_W-1:0]   target;
    } t_uword;

    typedef t_uword t_ucode [UCODE_DEPTH];

    // Jump to target when the condition holds, else fall through to the next step
    localparam t_ucode UCODE = '{
        '{UOP_ACCEPT,   COND_NO_INPUT,  STEP_ACCEPT},
        '{UOP_DIV_INIT, COND_NEVER,     STEP_ACCEPT},
        '{UOP_DIV_ITER, COND_LOOP_MORE, STEP_DIV},
        '{UOP_LOOKUP,   COND_NEVER,     STEP_ACCEPT},
        '{UOP_SQUARE,   COND_NEVER,     STEP_ACCEPT},
        '{UOP_SCALE,    COND_NEVER,     STEP_ACCEPT},
        '{UOP_EMIT,     COND_OUT_BUSY,  STEP_EMIT},
        '{UOP_NOP,      COND_ALWAYS,    STEP_ACCEPT}
    };

    typedef struct packed {
        t_uop uop;
    } t_dp_ctrl;

    typedef struct packed {
        logic out_free;
    } t_dp_status;

    typedef struct packed {
        logic [INTENSITY_BITS-1:0] max_intensity;
        logic [INTENSITY_BITS-1:0] start_phase;
        logic [CHANNEL_BITS-1:0]   target_channel;
    } t_cfg;

    typedef struct packed {
        logic [INTENSITY_BITS-1:0] position;
        logic                      write_enable;
        logic [INDEX_BITS-1:0]     compare_index;
        logic [INTENSITY_BITS-1:0] compare_value;
    } t_result;

    typedef logic [COS_W-1:0] t_cos_rom [0:COS_DEPTH];

    // Build cos(k*pi/(2*depth)) in Q0.15 from a 9-term Taylor series in Q30
    function automatic t_cos_rom f_build_cos();
        t_cos_rom           tab;
        logic [63:0]        x;
        logic [63:0]        x2;
        logic [63:0]        term;
        logic [63:0]        v;
        logic signed [63:0] sum;
        for (int k = 0; k <= COS_DEPTH; k++) begin
            x    = (HALF_PI_Q30 * 64'(k)) / COS_DEPTH;
            x2   = (x * x) >> 30;
            term = 64'd1 << 30;
            sum  = signed'(term);
            for (int n = 1; n <= 8; n++) begin
                term = (term * x2) >> 30;
                term = term / 64'((2 * n - 1) * (2 * n));
                if ((n & 1) != 0) begin
                    sum = sum - signed'(term);
                end else begin
                    sum = sum + signed'(term);
                end
            end
            if (sum < 0) begin
                sum = 64'sd0;
            end
            v = (unsigned'(sum) + (64'd1 << 14)) >> 15;
            if (v > 64'd32767) begin
                v = 64'd32767;
            end
            tab[k] = v[COS_W-1:0];
        end
        return tab;
    endfunction

    localparam t_cos_rom COS_ROM = f_build_cos();

endpackage

[hdl/bli_seq.sv]
module bli_seq (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  bli_pkg::t_dp_status i_status,
    output bli_pkg::t_dp_ctrl   o_ctrl
);

    logic [bli_pkg::STEP_W-1:0] r_pc;
    logic [bli_pkg::STEP_W-1:0] n_pc;
    logic [bli_pkg::LOOP_W-1:0] r_loop;
    logic [bli_pkg::LOOP_W-1:0] n_loop;
    bli_pkg::t_uword            w_word;
    logic                       w_take;

    assign w_word = bli_pkg::UCODE[r_pc];

    // Evaluate jump condition and pick the next step
    always_comb begin
        case (w_word.cond)
            bli_pkg::COND_NEVER:     w_take = 1'b0;
            bli_pkg::COND_ALWAYS:    w_take = 1'b1;
            bli_pkg::COND_NO_INPUT:  w_take = !i_in_valid;
            bli_pkg::COND_LOOP_MORE: w_take = (r_loop != '0);
            bli_pkg::COND_OUT_BUSY:  w_take = !i_status.out_free;
            default:                 w_take = 1'b0;
        endcase
        n_pc = w_take ? w_word.target : r_pc + 1'b1;
    end

    // Load the loop counter at divide start, count it down per iteration
    always_comb begin
        n_loop = r_loop;
        if (w_word.uop == bli_pkg::UOP_DIV_INIT) begin
            n_loop = bli_pkg::LOOP_W'(bli_pkg::DIV_STEPS - 1);
        end else if (w_word.uop == bli_pkg::UOP_DIV_ITER && r_loop != '0) begin
            n_loop = r_loop - 1'b1;
        end
    end

    // Drive the datapath from the current control word
    always_comb begin
        o_ctrl.uop = w_word.uop;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc   <= bli_pkg::STEP_ACCEPT;
            r_loop <= '0;
        end else begin
            r_pc   <= n_pc;
            r_loop <= n_loop;
        end
    end

endmodule

[hdl/bli_dp.sv]
module bli_dp (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  bli_pkg::t_dp_ctrl   i_ctrl,
    input  logic                i_in_valid,
    input  logic                i_restart,
    input  bli_pkg::t_cfg       i_cfg,
    output bli_pkg::t_dp_status o_status,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output bli_pkg::t_result    o_out_word
);

    localparam int IB = bli_pkg::INTENSITY_BITS;

    // Position state
    logic [IB-1:0]   r_pos;
    logic [IB-1:0]   n_pos;
    logic            r_down;
    logic            n_down;

    // Divider and arithmetic registers
    logic [IB-1:0]   r_rem;
    logic [2*IB-1:0] r_dvd;
    logic [IB-1:0]   r_quo;
    logic [IB-1:0]   r_s;
    logic [IB-1:0]   r_sq;
    logic [IB-1:0]   r_cmp;

    // Output register
    logic             r_out_valid;
    bli_pkg::t_result r_out;

    logic [IB-1:0]   w_top;
    logic            w_accept;
    logic            w_out_free;
    logic            w_load;
    logic            w_dir;
    logic [IB:0]     w_trial;
    logic [IB:0]     w_diff;
    logic            w_ge;
    logic [1:0]      w_quad;
    logic [bli_pkg::COS_IDX_W-1:0] w_idx;
    logic [bli_pkg::COS_SEL_W-1:0] w_mirror;
    logic [bli_pkg::COS_SEL_W-1:0] w_sel;
    logic [bli_pkg::COS_W-1:0]     w_cos;
    logic [IB-1:0]   w_s;
    logic [2*IB-1:0] w_sq_prod;
    logic [2*IB-1:0] w_scale_prod;
    logic            w_ch_ok;

    assign w_top      = i_cfg.max_intensity;
    assign w_accept   = (i_ctrl.uop == bli_pkg::UOP_ACCEPT) && i_in_valid;
    assign w_out_free = !r_out_valid || i_out_ready;
    assign w_load     = (i_ctrl.uop == bli_pkg::UOP_EMIT) && w_out_free;

    assign o_status.out_free = w_out_free;
    assign o_out_valid       = r_out_valid;
    assign o_out_word        = r_out;

    // Step the triangle counter, or reload it on restart
    always_comb begin
        w_dir  = r_down;
        n_pos  = r_pos;
        n_down = r_down;
        if (r_pos >= w_top) begin
            w_dir = 1'b1;
        end else if (r_pos == '0) begin
            w_dir = 1'b0;
        end
        if (w_accept) begin
            if (i_restart) begin
                n_pos  = (i_cfg.start_phase > w_top) ? w_top : i_cfg.start_phase;
                n_down = 1'b0;
            end else if (w_top == '0) begin
                n_pos  = '0;
                n_down = 1'b0;
            end else begin
                n_pos  = w_dir ? r_pos - 1'b1 : r_pos + 1'b1;
                n_down = w_dir;
            end
        end
    end

    // Restoring divide step: one quotient bit of (pos << 16) / top
    always_comb begin
        w_trial = {r_rem, r_dvd[2*IB-1]};
        w_ge    = (w_trial >= {1'b0, w_top});
        w_diff  = w_trial - {1'b0, w_top};
    end

    // Quarter-wave fold of the phase into one table read
    always_comb begin
        w_quad   = r_quo[IB-1 -: 2];
        w_idx    = r_quo[IB-3 -: bli_pkg::COS_IDX_W];
        w_mirror = bli_pkg::COS_SEL_W'(bli_pkg::COS_DEPTH) - {1'b0, w_idx};
        w_sel    = w_quad[0] ? w_mirror : {1'b0, w_idx};
        w_cos    = bli_pkg::COS_ROM[w_sel];
        if (w_quad[0] ^ w_quad[1]) begin
            w_s = 16'h8000 + {1'b0, w_cos};
        end else begin
            w_s = 16'h8000 - {1'b0, w_cos};
        end
    end

    assign w_sq_prod    = r_s * r_s;
    assign w_scale_prod = w_top * r_sq;
    assign w_ch_ok      = (i_cfg.target_channel >= 3'd1) && (i_cfg.target_channel <= 3'd4);

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos       <= '0;
            r_down      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_pos  <= n_pos;
            r_down <= n_down;
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Arithmetic registers, advanced by the current micro-op
    always_ff @(posedge i_clk) begin
        case (i_ctrl.uop)
            bli_pkg::UOP_DIV_INIT: begin
                r_rem <= '0;
                r_dvd <= {r_pos, {IB{1'b0}}};
                r_quo <= '0;
            end
            bli_pkg::UOP_DIV_ITER: begin
                r_rem <= w_ge ? w_diff[IB-1:0] : w_trial[IB-1:0];
                r_dvd <= {r_dvd[2*IB-2:0], 1'b0};
                r_quo <= {r_quo[IB-2:0], w_ge};
            end
            bli_pkg::UOP_LOOKUP: r_s   <= w_s;
            bli_pkg::UOP_SQUARE: r_sq  <= w_sq_prod[2*IB-1:IB];
            bli_pkg::UOP_SCALE:  r_cmp <= w_scale_prod[2*IB-1:IB];
            default: begin
            end
        endcase
    end

    // Hold the finished word until it is taken
    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_out.compare_value <= r_cmp;
            r_out.compare_index <= w_ch_ok ?
                bli_pkg::INDEX_BITS'(i_cfg.target_channel - 3'd1) : '0;
            r_out.write_enable  <= w_ch_ok;
            r_out.position      <= r_pos;
        end
    end

endmodule

[hdl/breathing_led_intensity.sv]
// Breathing LED intensity generator. Each accepted input word is one tick: with
// restart clear the triangle position moves one step between 0 and max_intensity,
// turning at either end; with restart set it reloads start_phase (clamped to the
// maximum) and counts upward. One output word follows each tick, carrying the
// compare value max*((1-cos(2*pi*pos/max))/2)^2, the channel index, the write enable
// (channels 1 to 4 only) and the new position. Ticks are handled one at a time by a
// small microcoded program that, after a word is accepted, runs the bit-serial phase
// divider, looks up the cosine, squares, scales and emits the result, waiting while
// the output side stalls, then returns to take the next word. The output register
// lets a new tick be accepted while the last result waits. Configuration writes
// take effect at once and should be made only while no tick is in flight.
module breathing_led_intensity (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Tick input
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [7:0]  i_s_axis_tdata,   // [0] restart, [7:1] zero
    // Result output
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [39:0] o_m_axis_tdata,   // [15:0] compare_value, [17:16] compare_index,
                                          // [18] write_enable, [34:19] position, [39:35] zero
    // Configuration
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_addr,
    input  logic [15:0] i_cfg_wdata
);

    bli_pkg::t_cfg       r_cfg;
    bli_pkg::t_dp_ctrl   w_ctrl;
    bli_pkg::t_dp_status w_status;
    bli_pkg::t_result    w_word;

    // Write configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.max_intensity  <= 16'd255;
            r_cfg.start_phase    <= 16'd0;
            r_cfg.target_channel <= 3'd1;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                bli_pkg::CFG_MAX_INTENSITY:  r_cfg.max_intensity  <= i_cfg_wdata;
                bli_pkg::CFG_START_PHASE:    r_cfg.start_phase    <= i_cfg_wdata;
                bli_pkg::CFG_TARGET_CHANNEL: r_cfg.target_channel <= i_cfg_wdata[2:0];
                default: begin
                end
            endcase
        end
    end

    bli_seq u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_axis_tvalid),
        .i_status   (w_status),
        .o_ctrl     (w_ctrl)
    );

    bli_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctrl      (w_ctrl),
        .i_in_valid  (i_s_axis_tvalid),
        .i_restart   (i_s_axis_tdata[0]),
        .i_cfg       (r_cfg),
        .o_status    (w_status),
        .o_out_valid (o_m_axis_tvalid),
        .i_out_ready (i_m_axis_tready),
        .o_out_word  (w_word)
    );

    assign o_s_axis_tready = (w_ctrl.uop == bli_pkg::UOP_ACCEPT);
    assign o_m_axis_tdata  = {5'b0, w_word};

endmodule
